FILE: src/picp_pkg.sv
// Package for the point-in-convex-polygon test block.
// Holds item types, operation codes and the fixed arithmetic widths.
// No dependencies.
package picp_pkg;

  // Coordinate width of vertices and points (signed Q16.4)
  localparam int COORD_BITS = 20;
  localparam int NRM_W      = 16;                       // normal, signed Q1.14
  localparam int DIFF_W     = COORD_BITS + 1;           // vertex differences
  localparam int EN_W       = DIFF_W + NRM_W + 1;       // edge normal component
  localparam int DIST_W     = DIFF_W + EN_W + 2;        // signed distance
  localparam int NN_W       = 2 * EN_W + 2;             // squared edge normal length
  localparam int TOL_W      = 32;
  localparam int MUL_W      = (DIST_W > NN_W + 1) ? DIST_W : NN_W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DIG_W      = 16;                       // multiplier digit
  localparam int DIG_N      = (MUL_W + DIG_W - 1) / DIG_W;
  localparam int VTX_W      = 3 * COORD_BITS;

  // Operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_NORMAL = 2'd1;
  localparam logic [1:0] OP_APPEND = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  typedef struct packed {
    logic [1:0]                   operation;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
    logic vertex_overflow;
  } out_item_t;

  // Snapshot of one query as it travels to the back end
  typedef struct packed {
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] pz;
    logic signed [NRM_W-1:0]      nx;
    logic signed [NRM_W-1:0]      ny;
    logic signed [NRM_W-1:0]      nz;
    logic                         ovf;
  } query_t;

endpackage

FILE: src/point_in_convex_polygon_test.sv
// Point-in-convex-polygon test block.
//
// Input channel (in_valid / in_stall / in_data) carries requests: clear polygon,
// set plane normal, append vertex, query point. A request is taken at a clock
// edge with in_valid high and in_stall low. Loads apply at that edge. An append
// is held off while an earlier query still walks the vertex store.
// Output channel (out_valid / out_stall / out_data) returns one result per
// query; it waits in the output register while out_stall is high, and the
// front end keeps accepting clears, normals and up to three more queries meanwhile.
// Configuration channel (cfg_valid / cfg_ready / cfg_data) writes tol_sq; it is
// always ready. The user must write it only while the block is idle; the block does not check.
// A query walks the polygon edges, one per stored vertex, in turn on the shared
// digit-serial multiplier in the back end; an edge whose signed distance is negative
// also runs a tolerance compare, and a failed compare ends the query early.
// Queries run one at a time; an empty polygon skips the walk. Reset (rst,
// synchronous) empties the polygon, zeroes the normal, the overflow flag and
// tol_sq; the vertex store holds no reset value and is read only below the
// vertex count.
module point_in_convex_polygon_test #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  picp_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output picp_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [picp_pkg::TOL_W-1:0] cfg_data
);
  import picp_pkg::*;

  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W  = $clog2(MAX_VERTICES);
  localparam int ENTRY_W = CNT_W + $bits(query_t);

  logic [TOL_W-1:0]   tol_sq;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_in;
  logic [ENTRY_W-1:0] q_out;
  logic               busy;
  logic               pending;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [VTX_W-1:0]   ram_wdata;
  logic [VTX_W-1:0]   ram_rdata;

  // tolerance register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tol_sq <= '0;
    end else if (cfg_valid && cfg_ready) begin
      tol_sq <= cfg_data;
    end
  end

  assign pending = busy || !q_empty;

  picp_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .CNT_W        (CNT_W),
    .ADDR_W       (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .pending   (pending),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  picp_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  picp_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  picp_back #(
    .CNT_W  (CNT_W),
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .busy      (busy),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .tol_sq    (tol_sq),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: src/picp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module picp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/picp_queue.sv
// Short request queue between front end and back end.
// No dependencies.
module picp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] level;

  assign full     = (level == LVL_W'(DEPTH));
  assign empty    = (level == '0);
  assign pop_data = slot[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

FILE: src/picp_mul.sv
// Shared sequential signed multiplier, one 16-bit digit of b per cycle.
// Depends on picp_pkg for operand and product widths.
module picp_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [picp_pkg::MUL_W-1:0]   a,
  input  logic signed [picp_pkg::MUL_W-1:0]   b,
  output logic                                done,
  output logic signed [picp_pkg::PROD_W-1:0]  prod
);
  import picp_pkg::*;

  localparam int MB_W  = DIG_N * DIG_W;
  localparam int ACC_W = MUL_W + MB_W;
  localparam int CNT_W = $clog2(DIG_N + 1);
  localparam int PP_W  = MUL_W + DIG_W;

  logic [MUL_W-1:0] ma;
  logic [MB_W-1:0]  mb;
  logic [ACC_W-1:0] acc;
  logic             neg;
  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [MUL_W-1:0] abs_a;
  logic [MUL_W-1:0] abs_b;
  logic [ACC_W-1:0] signed_acc;
  logic [PP_W-1:0]  pp;

  assign abs_a      = a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
  assign abs_b      = b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
  assign signed_acc = neg ? -acc : acc;
  assign prod       = PROD_W'(signed_acc);
  assign pp         = ma * mb[MB_W-1 -: DIG_W];

  // datapath: top digit first, accumulator shifts one digit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= abs_a;
      mb  <= MB_W'(abs_b);
      acc <= '0;
      neg <= a[MUL_W-1] ^ b[MUL_W-1];
    end else if (run) begin
      acc <= (acc << DIG_W) + ACC_W'(pp);
      mb  <= mb << DIG_W;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIG_N - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/picp_front.sv
// Front end: accepts requests, applies loads, queues query snapshots.
// Depends on picp_pkg; drives the vertex RAM write port and the queue.
module picp_front #(
  parameter int MAX_VERTICES = 64,
  parameter int CNT_W        = 7,
  parameter int ADDR_W       = 6
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  picp_pkg::in_item_t                         in_data,
  input  logic                                       pending,
  input  logic                                       q_full,
  output logic                                       q_push,
  output logic [CNT_W+$bits(picp_pkg::query_t)-1:0]  q_data,
  output logic                                       ram_we,
  output logic [ADDR_W-1:0]                          ram_waddr,
  output logic [picp_pkg::VTX_W-1:0]                 ram_wdata
);
  import picp_pkg::*;

  localparam int XW = (COORD_BITS > NRM_W) ? COORD_BITS + 1 : NRM_W + 1;
  localparam logic signed [XW-1:0] SAT_HI = XW'(32767);
  localparam logic signed [XW-1:0] SAT_LO = -XW'(32768);

  logic [CNT_W-1:0]        count;
  logic                    ovf;
  logic signed [NRM_W-1:0] nrm [3];
  logic signed [NRM_W-1:0] sat [3];
  logic signed [XW-1:0]    ext [3];
  logic                    accept;
  logic                    room;
  query_t                  snap;

  // saturate normal components to 16 bits
  always_comb begin
    ext[0] = XW'(in_data.coord_x);
    ext[1] = XW'(in_data.coord_y);
    ext[2] = XW'(in_data.coord_z);
    for (int c = 0; c < 3; c++) begin
      if (ext[c] > SAT_HI) begin
        sat[c] = NRM_W'(SAT_HI);
      end else if (ext[c] < SAT_LO) begin
        sat[c] = NRM_W'(SAT_LO);
      end else begin
        sat[c] = NRM_W'(ext[c]);
      end
    end
  end

  // appends wait while a query still reads the store; queries wait on a full queue
  assign in_stall = in_valid &&
                    (((in_data.operation == OP_APPEND) && pending) ||
                     ((in_data.operation == OP_QUERY) && q_full));
  assign accept   = in_valid && !in_stall;
  assign room     = (count < CNT_W'(MAX_VERTICES));

  assign snap.px  = in_data.coord_x;
  assign snap.py  = in_data.coord_y;
  assign snap.pz  = in_data.coord_z;
  assign snap.nx  = nrm[0];
  assign snap.ny  = nrm[1];
  assign snap.nz  = nrm[2];
  assign snap.ovf = ovf;

  assign q_push    = accept && (in_data.operation == OP_QUERY);
  assign q_data    = {count, snap};
  assign ram_we    = accept && (in_data.operation == OP_APPEND) && room;
  assign ram_waddr = ADDR_W'(count);
  assign ram_wdata = {in_data.coord_x, in_data.coord_y, in_data.coord_z};

  // polygon state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        nrm[c] <= '0;
      end
    end else if (accept) begin
      unique case (in_data.operation)
        OP_CLEAR: begin
          count <= '0;
          ovf   <= 1'b0;
        end
        OP_NORMAL: begin
          for (int c = 0; c < 3; c++) begin
            nrm[c] <= sat[c];
          end
        end
        OP_APPEND: begin
          if (room) begin
            count <= count + 1'b1;
          end else begin
            ovf <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: src/picp_back.sv
// Back end: walks the polygon edges for one query, drives the result register.
// Depends on picp_pkg and picp_mul; reads the vertex RAM.
module picp_back #(
  parameter int CNT_W  = 7,
  parameter int ADDR_W = 6
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       q_empty,
  input  logic [CNT_W+$bits(picp_pkg::query_t)-1:0]  q_data,
  output logic                                       q_pop,
  output logic                                       busy,
  output logic [ADDR_W-1:0]                          ram_raddr,
  input  logic [picp_pkg::VTX_W-1:0]                 ram_rdata,
  input  logic [picp_pkg::TOL_W-1:0]                 tol_sq,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output picp_pkg::out_item_t                        out_data
);
  import picp_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RDA   = 3'd1;
  localparam logic [2:0] ST_RDB   = 3'd2;
  localparam logic [2:0] ST_DIFF  = 3'd3;
  localparam logic [2:0] ST_ISSUE = 3'd4;
  localparam logic [2:0] ST_WAIT  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  // multiply steps of one edge
  localparam logic [3:0] U_EN0A = 4'd0;
  localparam logic [3:0] U_EN0B = 4'd1;
  localparam logic [3:0] U_EN1A = 4'd2;
  localparam logic [3:0] U_EN1B = 4'd3;
  localparam logic [3:0] U_EN2A = 4'd4;
  localparam logic [3:0] U_EN2B = 4'd5;
  localparam logic [3:0] U_DST0 = 4'd6;
  localparam logic [3:0] U_DST1 = 4'd7;
  localparam logic [3:0] U_DST2 = 4'd8;
  localparam logic [3:0] U_NN0  = 4'd9;
  localparam logic [3:0] U_NN1  = 4'd10;
  localparam logic [3:0] U_NN2  = 4'd11;
  localparam logic [3:0] U_LHS  = 4'd12;
  localparam logic [3:0] U_RHS  = 4'd13;

  logic [2:0]                   state;
  logic [3:0]                   step;
  logic [ADDR_W-1:0]            idx;
  logic [CNT_W-1:0]             cnt;
  query_t                       qry;
  logic                         in_poly;
  logic signed [COORD_BITS-1:0] va [3];
  logic signed [COORD_BITS-1:0] vb [3];
  logic signed [DIFF_W-1:0]     d  [3];
  logic signed [DIFF_W-1:0]     pa [3];
  logic signed [EN_W-1:0]       en [3];
  logic signed [EN_W-1:0]       t;
  logic signed [DIST_W-1:0]     dist_acc;
  logic [NN_W-1:0]              nn;
  logic [PROD_W-1:0]            sq;

  logic [CNT_W-1:0]             nxt;
  logic [ADDR_W-1:0]            k;
  logic                         last_edge;
  logic                         mul_start;
  logic                         mul_done;
  logic signed [MUL_W-1:0]      mul_a;
  logic signed [MUL_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]     prod;

  assign nxt       = CNT_W'(idx) + 1'b1;
  assign k         = (nxt < cnt) ? ADDR_W'(nxt) : '0;
  assign last_edge = (nxt == cnt);
  assign ram_raddr = (state == ST_RDB) ? k : idx;
  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign busy      = (state != ST_IDLE);
  assign mul_start = (state == ST_ISSUE);

  assign vb[0] = ram_rdata[VTX_W-1 -: COORD_BITS];
  assign vb[1] = ram_rdata[VTX_W-COORD_BITS-1 -: COORD_BITS];
  assign vb[2] = ram_rdata[COORD_BITS-1:0];

  // operand select for the shared multiplier
  always_comb begin
    case (step)
      U_EN0A:  begin mul_a = MUL_W'(d[1]);  mul_b = MUL_W'(qry.nz); end
      U_EN0B:  begin mul_a = MUL_W'(d[2]);  mul_b = MUL_W'(qry.ny); end
      U_EN1A:  begin mul_a = MUL_W'(d[2]);  mul_b = MUL_W'(qry.nx); end
      U_EN1B:  begin mul_a = MUL_W'(d[0]);  mul_b = MUL_W'(qry.nz); end
      U_EN2A:  begin mul_a = MUL_W'(d[0]);  mul_b = MUL_W'(qry.ny); end
      U_EN2B:  begin mul_a = MUL_W'(d[1]);  mul_b = MUL_W'(qry.nx); end
      U_DST0:  begin mul_a = MUL_W'(pa[0]); mul_b = MUL_W'(en[0]);  end
      U_DST1:  begin mul_a = MUL_W'(pa[1]); mul_b = MUL_W'(en[1]);  end
      U_DST2:  begin mul_a = MUL_W'(pa[2]); mul_b = MUL_W'(en[2]);  end
      U_NN0:   begin mul_a = MUL_W'(en[0]); mul_b = MUL_W'(en[0]);  end
      U_NN1:   begin mul_a = MUL_W'(en[1]); mul_b = MUL_W'(en[1]);  end
      U_NN2:   begin mul_a = MUL_W'(en[2]); mul_b = MUL_W'(en[2]);  end
      U_LHS:   begin mul_a = MUL_W'(dist_acc); mul_b = MUL_W'(dist_acc); end
      U_RHS:   begin mul_a = MUL_W'(tol_sq); mul_b = MUL_W'(nn);    end
      default: begin mul_a = '0;            mul_b = '0;             end
    endcase
  end

  picp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  // edge sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= U_EN0A;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            {cnt, qry} <= q_data;
            in_poly    <= 1'b1;
            idx        <= '0;
            state      <= (q_data[$bits(query_t) +: CNT_W] == '0) ? ST_DONE : ST_RDA;
          end
        end
        ST_RDA: begin
          state <= ST_RDB;
        end
        ST_RDB: begin
          for (int c = 0; c < 3; c++) begin
            va[c] <= vb[c];
          end
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          for (int c = 0; c < 3; c++) begin
            d[c] <= DIFF_W'(vb[c]) - DIFF_W'(va[c]);
          end
          pa[0] <= DIFF_W'(qry.px) - DIFF_W'(va[0]);
          pa[1] <= DIFF_W'(qry.py) - DIFF_W'(va[1]);
          pa[2] <= DIFF_W'(qry.pz) - DIFF_W'(va[2]);
          step  <= U_EN0A;
          state <= ST_ISSUE;
        end
        ST_ISSUE: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mul_done) begin
            case (step)
              U_EN0A, U_EN1A, U_EN2A: t <= EN_W'(prod);
              U_EN0B: en[0] <= t - EN_W'(prod);
              U_EN1B: en[1] <= t - EN_W'(prod);
              U_EN2B: en[2] <= t - EN_W'(prod);
              U_DST0: dist_acc <= DIST_W'(prod);
              U_DST1, U_DST2: dist_acc <= dist_acc + DIST_W'(prod);
              U_NN0: nn <= NN_W'(prod);
              U_NN1, U_NN2: nn <= nn + NN_W'(prod);
              U_LHS: sq <= prod;
              default: begin
              end
            endcase
            // edge passes: either the sign test holds or the tolerance compare passes
            if ((step == U_NN2 && !dist_acc[DIST_W-1]) ||
                (step == U_RHS && !(sq > PROD_W'(prod)))) begin
              if (last_edge) begin
                state <= ST_DONE;
              end else begin
                idx   <= idx + 1'b1;
                state <= ST_RDA;
              end
            end else if (step == U_RHS) begin
              in_poly <= 1'b0;
              state   <= ST_DONE;
            end else begin
              state <= ST_ISSUE;
              step  <= step + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid                <= 1'b1;
            out_data.inside_res      <= in_poly;
            out_data.vertex_overflow <= qry.ovf;
            state                    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // multiplier results only arrive while the sequencer waits for them
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_WAIT))
    else $error("multiplier result outside wait state");

  // a finished query with a free result register always posts its result
  a_done_posts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_valid) |=> (out_valid && state == ST_IDLE))
    else $error("result not posted");

  // popping the queue always takes the sequencer out of idle
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state != ST_IDLE))
    else $error("pop did not start a query");

  // a held result stays put while stalled
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule
